// File: hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hw/rtl/lpht_pkg.sv
package lpht_pkg;
  localparam int LogCap = 10;
  localparam int ValBits = 32;
  localparam int CntBits = LogCap + 1;
  localparam logic [63:0] HashBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] HashPrime = 64'h00000100000001B3;
  typedef logic [LogCap-1:0] slot_t;

  localparam logic [1:0] REQ_FIND = 2'd0;
  localparam logic [1:0] REQ_INS  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;
  localparam logic [1:0] REQ_DLF  = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NF    = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  localparam logic [9:0] LoadLimitRst = 10'd512;
endpackage

// File: hw/rtl/lpht_if.sv
interface lpht_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [63:0] key;
  logic [31:0] value_in;
  modport source(output valid, req_type, key, value_in, input ready);
  modport sink(input valid, req_type, key, value_in, output ready);
endinterface

interface lpht_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [31:0] value_out;
  modport source(output valid, status, value_out, input ready);
  modport sink(input valid, status, value_out, output ready);
endinterface

// File: hw/rtl/lpht_hash.sv
// Home slot: low bits of (basis ^ key) * prime, accumulated from 16-bit partial products.
module lpht_hash (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           key,
  output logic                  done,
  output lpht_pkg::slot_t       slot
);
  import lpht_pkg::*;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] part;

  // prime = 2^40 + 0x1B3, so x * prime = (x << 40) + x * 0x1B3
  always_comb begin
    part = ({48'd0, x_r[16*step_r +: 16]} * 64'h1B3) << (16 * step_r);
  end

  always_comb begin
    x_nxt = x_r;
    acc_nxt = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt = HashBasis ^ key;
      acc_nxt = (HashBasis ^ key) << 40;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + part;
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign slot = acc_r[LogCap-1:0];
endmodule

// File: hw/rtl/linear_probe_hash_table.sv
// Open-addressed hash table of 1024 slots, 64-bit nonzero keys and 32-bit
// values, linear probing and backward-shift delete. One transaction at a
// time: the input is not ready until the result has been taken. After reset
// a clearing pass over all 1024 slots empties the key and value memories
// before the first transaction. A request passes through the accept, the
// hash and the result (delete of the last found slot skips hashing, and a
// zero-key or over-limit insert goes straight to the result), with a
// registered memory read and check per probed slot; a delete then walks the
// following slots, hashing the key of each occupied one, moving entries
// back and clearing the final gap. Backpressure holds the result. A single
// hash unit and one-read, one-write key/value memories serve each request.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  lpht_req_if.sink    in_ch,
  lpht_rsp_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lpht_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_HASH  = 12'b000000000100,
    S_RD    = 12'b000000001000,
    S_CHK   = 12'b000000010000,
    S_GNEXT = 12'b000000100000,
    S_GRD   = 12'b000001000000,
    S_GCHK  = 12'b000010000000,
    S_GHASH = 12'b000100000000,
    S_GMOVE = 12'b001000000000,
    S_GEND  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  localparam int Cap = 1 << LogCap;

  state_t state_r, state_nxt;
  logic [63:0] key_mem [Cap];
  logic [31:0] val_mem [Cap];

  logic [1:0]  req_r, req_nxt;
  logic [63:0] key_r, key_nxt;
  logic [31:0] vin_r, vin_nxt;
  slot_t       s_r, s_nxt;
  logic [CntBits-1:0] n_r, n_nxt;
  slot_t       gi_r, gi_nxt, gj_r, gj_nxt;
  logic [63:0] mkey_r;
  logic [31:0] mval_r;
  logic [63:0] hkey_r, hkey_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] vout_r, vout_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  slot_t       lf_r, lf_nxt;
  logic [9:0]  limit_r;
  logic        hstart;
  logic        hdone;
  slot_t       hslot;

  logic        we;
  slot_t       waddr, raddr;
  logic [63:0] wkey;
  logic [31:0] wval;
  logic        cfg_wr;

  lpht_hash u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hstart),
    .key  (hkey_nxt),
    .done (hdone),
    .slot (hslot)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    mkey_r <= key_mem[raddr];
    mval_r <= val_mem[raddr];
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {22'd0, limit_r} : 32'd0;

  logic mv_ok;
  always_comb begin
    mv_ok = 1'b0;
    if (gj_r > gi_r) mv_ok = (hslot <= gi_r) || (hslot > gj_r);
    else mv_ok = (hslot <= gi_r) && (hslot > gj_r);
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    key_nxt = key_r;
    vin_nxt = vin_r;
    s_nxt = s_r;
    n_nxt = n_r;
    gi_nxt = gi_r;
    gj_nxt = gj_r;
    hkey_nxt = hkey_r;
    st_nxt = st_r;
    vout_nxt = vout_r;
    cnt_nxt = cnt_r;
    lf_nxt = lf_r;
    hstart = 1'b0;
    we = 1'b0;
    waddr = s_r;
    raddr = s_r;
    wkey = 64'd0;
    wval = 32'd0;
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        s_nxt = s_r + 1'b1;
        if (s_r == slot_t'(Cap - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.req_type;
          key_nxt = in_ch.key;
          vin_nxt = in_ch.value_in;
          st_nxt = ST_NF;
          vout_nxt = 32'd0;
          n_nxt = '0;
          if (in_ch.req_type == REQ_INS && in_ch.key == 64'd0) begin
            st_nxt = ST_ZERO;
            state_nxt = S_OUT;
          end else if (in_ch.req_type == REQ_INS && cnt_r >= {1'b0, limit_r}) begin
            st_nxt = ST_FULL;
            state_nxt = S_OUT;
          end else if (in_ch.req_type == REQ_DLF) begin
            s_nxt = lf_r;
            state_nxt = S_RD;
          end else begin
            hkey_nxt = in_ch.key;
            hstart = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hdone) begin
          s_nxt = hslot;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (req_r == REQ_DLF) begin
          if (mkey_r == 64'd0) state_nxt = S_OUT;
          else begin
            gi_nxt = s_r;
            gj_nxt = s_r;
            state_nxt = S_GNEXT;
          end
        end else if (mkey_r == 64'd0) begin
          if (req_r == REQ_INS) begin
            we = 1'b1;
            wkey = key_r;
            wval = vin_r;
            cnt_nxt = cnt_r + 1'b1;
            st_nxt = ST_OK;
          end
          state_nxt = S_OUT;
        end else if (mkey_r == key_r) begin
          case (req_r)
            REQ_FIND: begin
              st_nxt = ST_OK;
              vout_nxt = mval_r;
              lf_nxt = s_r;
              state_nxt = S_OUT;
            end
            REQ_INS: begin
              st_nxt = ST_DUP;
              state_nxt = S_OUT;
            end
            default: begin
              gi_nxt = s_r;
              gj_nxt = s_r;
              state_nxt = S_GNEXT;
            end
          endcase
        end else if (n_r == CntBits'(Cap - 1)) begin
          if (req_r == REQ_INS) st_nxt = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          n_nxt = n_r + 1'b1;
          s_nxt = s_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_GNEXT: begin
        gj_nxt = gj_r + 1'b1;
        if (slot_t'(gj_r + 1'b1) == gi_r) state_nxt = S_GEND;
        else state_nxt = S_GRD;
      end
      S_GRD: begin
        raddr = gj_r;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (mkey_r == 64'd0) state_nxt = S_GEND;
        else begin
          hkey_nxt = mkey_r;
          hstart = 1'b1;
          state_nxt = S_GHASH;
        end
      end
      S_GHASH: begin
        raddr = gj_r;
        if (hdone) begin
          if (mv_ok) state_nxt = S_GMOVE;
          else state_nxt = S_GNEXT;
        end
      end
      S_GMOVE: begin
        we = 1'b1;
        waddr = gi_r;
        wkey = mkey_r;
        wval = mval_r;
        gi_nxt = gj_r;
        state_nxt = S_GNEXT;
      end
      S_GEND: begin
        we = 1'b1;
        waddr = gi_r;
        cnt_nxt = cnt_r - 1'b1;
        st_nxt = ST_OK;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      s_r <= '0;
      cnt_r <= '0;
      lf_r <= '0;
      limit_r <= LoadLimitRst;
    end else begin
      state_r <= state_nxt;
      s_r <= s_nxt;
      cnt_r <= cnt_nxt;
      lf_r <= lf_nxt;
      if (cfg_wr && cfg_paddr == 2'd0) limit_r <= cfg_pwdata[9:0];
    end
    req_r <= req_nxt;
    key_r <= key_nxt;
    vin_r <= vin_nxt;
    n_r <= n_nxt;
    gi_r <= gi_nxt;
    gj_r <= gj_nxt;
    hkey_r <= hkey_nxt;
    st_r <= st_nxt;
    vout_r <= vout_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = st_r;
  assign out_ch.value_out = vout_r;

  `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CntBits'(Cap))
  `ASSERT_IMPL(a_vout_zero, clk, rst_n, out_ch.valid && st_r != ST_OK, vout_r == 32'd0)
  `ASSERT_NEXT(a_ins_cnt, clk, rst_n, state_r == S_CHK && we && req_r == REQ_INS,
               cnt_r == $past(cnt_r) + 1'b1)
  `ASSERT_IMPL(a_no_both, clk, rst_n, 1'b1, !(in_ch.ready && out_ch.valid))
endmodule
